FILE: design/dnsr_pkg.sv
// Shared types and constants for the DNS reply first-A-record parser.
// No dependencies; the parser, output buffer, top level and checker import this package.
package dnsr_pkg;

  localparam int StatusW = 2;
  localparam int AddrW   = 32;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_FOUND = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD   = 2'd1;
  localparam logic [StatusW-1:0] ST_TRUNC = 2'd2;

  // Message layout constants.
  localparam logic [7:0]  PTR_MARK     = 8'hc0;
  localparam logic [15:0] HEADER_BYTES = 16'd12;
  localparam logic [15:0] QFIX_BYTES   = 16'd4;
  localparam logic [15:0] RFIX_BYTES   = 16'd10;
  localparam logic [15:0] ADDR_BYTES   = 16'd4;
  localparam logic [15:0] TYPE_A       = 16'd1;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   address;
  } dnsr_result_t;

endpackage

FILE: design/dnsr_msg_if.sv
// Input channel: one reply byte per beat with a last-byte mark.
// Depends on nothing.
interface dnsr_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       last_byte;

  modport source (output valid, output reply_byte, output last_byte, input ready);
  modport sink   (input valid, input reply_byte, input last_byte, output ready);
endinterface

FILE: design/dnsr_res_if.sv
// Result channel: one status and address per beat.
// Depends on nothing.
interface dnsr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;

  modport source (output valid, output status, output address, input ready);
  modport sink   (input valid, input status, input address, output ready);
endinterface

FILE: design/dnsr_parser.sv
// Byte-serial parse state and its next-state logic.
// Depends on dnsr_pkg.
module dnsr_parser
  import dnsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   reply_byte,
  input  logic         last_byte,
  output logic         hit,
  output dnsr_result_t hit_result
);

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QLEN   = 4'd1;
  localparam logic [3:0] PH_QPTR   = 4'd2;
  localparam logic [3:0] PH_QLABEL = 4'd3;
  localparam logic [3:0] PH_QFIX   = 4'd4;
  localparam logic [3:0] PH_ALEN   = 4'd5;
  localparam logic [3:0] PH_APTR   = 4'd6;
  localparam logic [3:0] PH_ALABEL = 4'd7;
  localparam logic [3:0] PH_RFIX   = 4'd8;
  localparam logic [3:0] PH_ADDR   = 4'd9;
  localparam logic [3:0] PH_DATA   = 4'd10;

  logic [3:0]  phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] answers_left, answers_left_next;
  logic [31:0] field_shift, field_shift_next;
  logic [15:0] record_type, record_type_next;
  logic        decided, decided_next;

  logic [31:0] shifted;
  logic [15:0] cnt_inc, cnt_dec, ans_dec;
  logic        is_ptr;

  always_comb begin
    shifted = {field_shift[23:0], reply_byte};
    cnt_inc = byte_count + 16'd1;
    cnt_dec = byte_count - 16'd1;
    ans_dec = answers_left - 16'd1;
    is_ptr  = (reply_byte & PTR_MARK) == PTR_MARK;

    phase_next        = phase;
    byte_count_next   = byte_count;
    answers_left_next = answers_left;
    field_shift_next  = field_shift;
    record_type_next  = record_type;
    decided_next      = decided;
    hit                = 1'b0;
    hit_result.status  = ST_BAD;
    hit_result.address = '0;

    if (fire) begin
      if (!decided) begin
        case (phase)
          PH_HEADER: begin
            if (byte_count == 16'd2 && !reply_byte[7]) begin
              hit          = 1'b1;
              decided_next = 1'b1;
            end else begin
              if (byte_count == 16'd6) answers_left_next = {reply_byte, 8'h00};
              if (byte_count == 16'd7) answers_left_next = answers_left | {8'h00, reply_byte};
              byte_count_next = cnt_inc;
              if (cnt_inc >= HEADER_BYTES) begin
                if (answers_left_next == 16'd0) begin
                  hit          = 1'b1;
                  decided_next = 1'b1;
                end else begin
                  phase_next      = PH_QLEN;
                  byte_count_next = '0;
                end
              end
            end
          end
          PH_QLEN, PH_ALEN: begin
            if (is_ptr) begin
              phase_next = (phase == PH_QLEN) ? PH_QPTR : PH_APTR;
            end else if (reply_byte == 8'd0) begin
              phase_next       = (phase == PH_QLEN) ? PH_QFIX : PH_RFIX;
              byte_count_next  = '0;
              field_shift_next = '0;
            end else begin
              phase_next      = (phase == PH_QLEN) ? PH_QLABEL : PH_ALABEL;
              byte_count_next = {8'h00, reply_byte};
            end
          end
          PH_QPTR: begin
            phase_next      = PH_QFIX;
            byte_count_next = '0;
          end
          PH_APTR: begin
            phase_next       = PH_RFIX;
            byte_count_next  = '0;
            field_shift_next = '0;
          end
          PH_QLABEL, PH_ALABEL: begin
            byte_count_next = cnt_dec;
            if (cnt_dec == 16'd0) phase_next = (phase == PH_QLABEL) ? PH_QLEN : PH_ALEN;
          end
          PH_QFIX: begin
            byte_count_next = cnt_inc;
            if (cnt_inc >= QFIX_BYTES) phase_next = PH_ALEN;
          end
          PH_RFIX: begin
            field_shift_next = shifted;
            if (byte_count == 16'd1) record_type_next = shifted[15:0];
            byte_count_next = cnt_inc;
            if (cnt_inc >= RFIX_BYTES) begin
              field_shift_next = '0;
              if (record_type_next == TYPE_A) begin
                phase_next      = PH_ADDR;
                byte_count_next = '0;
              end else if (shifted[15:0] == 16'd0) begin
                // Empty data area: the record ends right here.
                answers_left_next = ans_dec;
                if (ans_dec == 16'd0) begin
                  hit          = 1'b1;
                  decided_next = 1'b1;
                end else begin
                  phase_next = PH_ALEN;
                end
              end else begin
                phase_next      = PH_DATA;
                byte_count_next = shifted[15:0];
              end
            end
          end
          PH_ADDR: begin
            field_shift_next = shifted;
            byte_count_next  = cnt_inc;
            if (cnt_inc >= ADDR_BYTES) begin
              hit                = 1'b1;
              decided_next       = 1'b1;
              hit_result.status  = ST_FOUND;
              hit_result.address = shifted;
            end
          end
          PH_DATA: begin
            byte_count_next = cnt_dec;
            if (cnt_dec == 16'd0) begin
              answers_left_next = ans_dec;
              if (ans_dec == 16'd0) begin
                hit          = 1'b1;
                decided_next = 1'b1;
              end else begin
                phase_next = PH_ALEN;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (last_byte) begin
        if (!decided_next) begin
          hit                = 1'b1;
          hit_result.status  = ST_TRUNC;
          hit_result.address = '0;
        end
        phase_next        = PH_HEADER;
        byte_count_next   = '0;
        answers_left_next = '0;
        field_shift_next  = '0;
        record_type_next  = '0;
        decided_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= '0;
      answers_left <= '0;
      field_shift  <= '0;
      record_type  <= '0;
      decided      <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      answers_left <= answers_left_next;
      field_shift  <= field_shift_next;
      record_type  <= record_type_next;
      decided      <= decided_next;
    end
  end

endmodule

FILE: design/dnsr_out_buf.sv
// Result register with a skid entry behind it.
// Depends on dnsr_pkg.
module dnsr_out_buf
  import dnsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dnsr_result_t push_data,
  output logic         space,
  output logic         valid,
  input  logic         ready,
  output dnsr_result_t data
);

  logic         skid_valid;
  dnsr_result_t skid_data;
  logic         take;

  assign take  = valid && ready;
  // The skid entry is the only thing that can hold off new bytes.
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!valid || take) begin
      valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) data <= skid_data;
    end else if (!valid || take) begin
      if (push) data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: design/dns_reply_first_a_record.sv
// DNS reply parser that reports the first A record of a reply message.
// Each result is decided combinationally from its byte and registered in the output buffer.
// Throughput: one byte per cycle while the input is not stalled; the parse state updates on each accepted byte.
// Input stalls only when both the result register and its skid entry are full.
// Reset (rst, synchronous, active high) returns the parser to the header phase
// and empties the result register and skid entry.
module dns_reply_first_a_record
  import dnsr_pkg::*;
(
  input logic           clk,
  input logic           rst,
  dnsr_msg_if.sink      msg,
  dnsr_res_if.source    result
);

  // A beat is taken whenever the output side can still absorb a result. Most
  // bytes produce no result at all, so the parser keeps running while a
  // finished result waits in the output register.
  logic         fire;
  logic         hit;
  dnsr_result_t hit_result;
  logic         space;
  dnsr_result_t out_data;

  assign msg.ready = space;
  assign fire      = msg.valid && space;

  // The parser holds the phase, counters and field shift register and decides
  // in the same cycle as the byte that completes a decision. The last byte of
  // a message always rearms it; a message that ends undecided reports a
  // truncation on that byte.
  dnsr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .reply_byte (msg.reply_byte),
    .last_byte  (msg.last_byte),
    .hit        (hit),
    .hit_result (hit_result)
  );

  // The result register with one skid entry parts the two handshakes, so a
  // stalled consumer costs nothing until a second result is produced.
  dnsr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (hit),
    .push_data (hit_result),
    .space     (space),
    .valid     (result.valid),
    .ready     (result.ready),
    .data      (out_data)
  );

  assign result.status  = out_data.status;
  assign result.address = out_data.address;

endmodule

FILE: design/dnsr_checker.sv
// Port-level checks for the DNS reply parser, bound to its top level.
// Depends on dnsr_pkg and the dns_reply_first_a_record ports.
module dnsr_checker
  import dnsr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        msg_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_status,
  input logic [31:0] res_address
);

  // Only a full result register can hold off the input.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !msg_ready |-> res_valid)
    else $error("input stalled with no pending result");

  // Reported addresses are zero unless an A record was found.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_FOUND |-> res_address == 32'd0)
    else $error("nonzero address with non-found status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status == ST_FOUND || res_status == ST_BAD || res_status == ST_TRUNC)
    else $error("undefined status code");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_address))
    else $error("stalled result changed");

endmodule

bind dns_reply_first_a_record dnsr_checker u_dnsr_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_ready   (msg.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_status  (result.status),
  .res_address (result.address)
);
